// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication check, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication check, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- rtl/vpa_pkg.sv -----
package vpa_pkg;

    localparam int MAX_SEGMENTS_DEF = 32;
    localparam int ADDR_BITS_DEF    = 16;

    typedef enum logic [2:0] {
        MODE_INIT    = 3'd0,
        MODE_ALLOC   = 3'd1,
        MODE_RELEASE = 3'd2,
        MODE_MERGE   = 3'd3,
        MODE_COMPACT = 3'd4
    } mode_e;

    typedef enum logic [1:0] {
        FIT_FIRST = 2'd0,
        FIT_BEST  = 2'd1,
        FIT_WORST = 2'd2
    } fit_e;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_NO_FIT  = 2'd1,
        ST_NO_SEG  = 2'd2,
        ST_ZERO    = 2'd3
    } status_e;

    typedef enum logic [3:0] {
        S_IDLE,
        S_INIT,
        S_SEARCH,
        S_SPLIT,
        S_MERGE,
        S_COMPACT,
        S_CPT_TAIL,
        S_CLEAR,
        S_STATS,
        S_DONE
    } state_t;

    localparam logic [1:0] REG_TOTAL_SIZE = 2'd0;

    // Per-entry step of the shared unit
    typedef struct packed {
        logic        valid;
        logic        free;
        logic [31:0] length;
    } scan_t;

endpackage

// ----- rtl/variable_partition_allocator_core.sv -----
// Variable partition allocator.
// Command channel: a request is taken when start is high and busy is low.
// mode selects init, allocate (first/best/worst fit), release, merge or compact.
// While a request runs, busy stays high and no other request is taken.
// The table is walked one entry per cycle through one read and one write port.
// An allocate with a split also shifts the entries above the pick up by one;
// release stops at the matching entry.
// The result is held on the output ports and marked by done for one cycle;
// the receiver must take it then, it cannot stall the block.
// total_size is written at APB address 0, by the user only while idle (nothing
// in the block enforces this), and is used by the next init request.
// After reset the block builds one free segment of size total_size
// (reset 65535), gives no result for it, then is idle.
module variable_partition_allocator_core #(
    parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = vpa_pkg::ADDR_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        start,
    output logic        busy,
    input  logic [2:0]  mode,
    input  logic [1:0]  fit_rule,
    input  logic [7:0]  owner_id,
    input  logic [15:0] request_size,
    input  logic [15:0] release_start,
    output logic        done,
    output logic [1:0]  status,
    output logic [15:0] granted_start,
    output logic [15:0] granted_size,
    output logic [15:0] free_total,
    output logic [5:0]  hole_count,
    output logic [15:0] largest_hole
);
    import vpa_pkg::*;

    logic [15:0] total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg <= 16'hFFFF;
        end
        else if (psel && penable && pwrite && paddr == '0)
        begin
            total_reg <= pwdata[15:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = {16'd0, total_reg};

    vpa_ctrl #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .mode          (mode),
        .fit_rule      (fit_rule),
        .owner_id      (owner_id),
        .request_size  (request_size),
        .release_start (release_start),
        .total_size    (ADDR_BITS'(total_reg)),
        .done          (done),
        .status        (status),
        .granted_start (granted_start),
        .granted_size  (granted_size),
        .free_total    (free_total),
        .hole_count    (hole_count),
        .largest_hole  (largest_hole)
    );

endmodule

// ----- rtl/vpa_table.sv -----
// Segment table: register file with indexed read and write.
module vpa_table #(
    parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = vpa_pkg::ADDR_BITS_DEF,
    parameter int IDX_BITS     = $clog2(MAX_SEGMENTS)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [IDX_BITS-1:0]  wr_idx,
    input  logic [ADDR_BITS-1:0] wr_start,
    input  logic [ADDR_BITS-1:0] wr_length,
    input  logic                 wr_free,
    input  logic [7:0]           wr_owner,
    input  logic [IDX_BITS-1:0]  rd_idx,
    output logic [ADDR_BITS-1:0] rd_start,
    output logic [ADDR_BITS-1:0] rd_length,
    output logic                 rd_free,
    output logic [7:0]           rd_owner
);
    import vpa_pkg::*;

    logic [ADDR_BITS-1:0] start_mem  [MAX_SEGMENTS];
    logic [ADDR_BITS-1:0] length_mem [MAX_SEGMENTS];
    logic [7:0]           owner_mem  [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] free_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_reg <= '0;
        end
        else if (wr_en)
        begin
            free_reg[wr_idx] <= wr_free;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            start_mem[wr_idx]  <= wr_start;
            length_mem[wr_idx] <= wr_length;
            owner_mem[wr_idx]  <= wr_owner;
        end
    end

    always_comb
    begin
        rd_start  = start_mem[rd_idx];
        rd_length = length_mem[rd_idx];
        rd_owner  = owner_mem[rd_idx];
        rd_free   = free_reg[rd_idx];
    end

endmodule

// ----- rtl/vpa_ctrl.sv -----
// Sequencer: one table entry per cycle through a shared read port and write port.
module vpa_ctrl #(
    parameter int MAX_SEGMENTS = vpa_pkg::MAX_SEGMENTS_DEF,
    parameter int ADDR_BITS    = vpa_pkg::ADDR_BITS_DEF,
    parameter int IDX_BITS     = $clog2(MAX_SEGMENTS),
    parameter int CNT_BITS     = $clog2(MAX_SEGMENTS + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [2:0]           mode,
    input  logic [1:0]           fit_rule,
    input  logic [7:0]           owner_id,
    input  logic [15:0]          request_size,
    input  logic [15:0]          release_start,
    input  logic [ADDR_BITS-1:0] total_size,
    output logic                 done,
    output logic [1:0]           status,
    output logic [15:0]          granted_start,
    output logic [15:0]          granted_size,
    output logic [15:0]          free_total,
    output logic [5:0]           hole_count,
    output logic [15:0]          largest_hole
);
    import vpa_pkg::*;

    localparam logic [CNT_BITS-1:0] MAXC = CNT_BITS'(MAX_SEGMENTS);

    state_t state_reg, state_next;
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [CNT_BITS-1:0] idx_reg, idx_next;   // read pointer
    logic [CNT_BITS-1:0] wp_reg, wp_next;     // write pointer
    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  rule_reg, rule_next;
    logic [7:0]  own_reg, own_next;
    logic [ADDR_BITS-1:0] size_reg, size_next;
    logic [ADDR_BITS-1:0] rel_reg, rel_next;
    logic [1:0]  st_reg, st_next;
    logic        pick_ok_reg, pick_ok_next;
    logic [CNT_BITS-1:0] pick_reg, pick_next;
    logic [ADDR_BITS-1:0] pick_len_reg, pick_len_next;
    logic [ADDR_BITS-1:0] acc_reg, acc_next;     // running length / address
    logic                 acc_free_reg, acc_free_next;
    logic [ADDR_BITS-1:0] acc_start_reg, acc_start_next;
    logic [7:0]           acc_own_reg, acc_own_next;
    logic                 have_reg, have_next;
    logic [ADDR_BITS-1:0] fsum_reg, fsum_next;
    logic [ADDR_BITS-1:0] gs_reg, gs_next, gz_reg, gz_next;
    logic [ADDR_BITS-1:0] tot_reg, tot_next;
    logic [5:0]           holes_reg, holes_next;
    logic [ADDR_BITS-1:0] big_reg, big_next;
    logic                 done_reg, done_next;
    logic                 boot_reg, boot_next;   // table build after reset, no result

    logic                 wr_en;
    logic [IDX_BITS-1:0]  wr_idx, rd_idx;
    logic [ADDR_BITS-1:0] wr_start, wr_length, rd_start, rd_length;
    logic                 wr_free, rd_free;
    logic [7:0]           wr_owner, rd_owner;
    logic [ADDR_BITS:0]   sum_w;

    vpa_table #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .ADDR_BITS    (ADDR_BITS),
        .IDX_BITS     (IDX_BITS)
    ) u_table (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_en     (wr_en),
        .wr_idx    (wr_idx),
        .wr_start  (wr_start),
        .wr_length (wr_length),
        .wr_free   (wr_free),
        .wr_owner  (wr_owner),
        .rd_idx    (rd_idx),
        .rd_start  (rd_start),
        .rd_length (rd_length),
        .rd_free   (rd_free),
        .rd_owner  (rd_owner)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            cnt_reg   <= '0;
            idx_reg   <= '0;
            wp_reg    <= '0;
            done_reg  <= 1'b0;
            tot_reg   <= {ADDR_BITS{1'b1}};
            mode_reg  <= MODE_INIT;
            boot_reg  <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            idx_reg   <= idx_next;
            wp_reg    <= wp_next;
            done_reg  <= done_next;
            tot_reg   <= tot_next;
            mode_reg  <= mode_next;
            boot_reg  <= boot_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rule_reg      <= rule_next;
        own_reg       <= own_next;
        size_reg      <= size_next;
        rel_reg       <= rel_next;
        st_reg        <= st_next;
        pick_ok_reg   <= pick_ok_next;
        pick_reg      <= pick_next;
        pick_len_reg  <= pick_len_next;
        acc_reg       <= acc_next;
        acc_free_reg  <= acc_free_next;
        acc_start_reg <= acc_start_next;
        acc_own_reg   <= acc_own_next;
        have_reg      <= have_next;
        fsum_reg      <= fsum_next;
        gs_reg        <= gs_next;
        gz_reg        <= gz_next;
        holes_reg     <= holes_next;
        big_reg       <= big_next;
    end

    assign rd_idx = idx_reg[IDX_BITS-1:0];
    assign sum_w  = {1'b0, acc_reg} + {1'b0, rd_length};

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        idx_next       = idx_reg;
        wp_next        = wp_reg;
        mode_next      = mode_reg;
        rule_next      = rule_reg;
        own_next       = own_reg;
        size_next      = size_reg;
        rel_next       = rel_reg;
        st_next        = st_reg;
        pick_ok_next   = pick_ok_reg;
        pick_next      = pick_reg;
        pick_len_next  = pick_len_reg;
        acc_next       = acc_reg;
        acc_free_next  = acc_free_reg;
        acc_start_next = acc_start_reg;
        acc_own_next   = acc_own_reg;
        have_next      = have_reg;
        fsum_next      = fsum_reg;
        gs_next        = gs_reg;
        gz_next        = gz_reg;
        tot_next       = tot_reg;
        holes_next     = holes_reg;
        big_next       = big_reg;
        boot_next      = boot_reg;
        done_next      = 1'b0;
        wr_en          = 1'b0;
        wr_idx         = wp_reg[IDX_BITS-1:0];
        wr_start       = '0;
        wr_length      = '0;
        wr_free        = 1'b0;
        wr_owner       = '0;

        case (state_reg)
            S_IDLE:
            begin
                tot_next = total_size;
                if (start)
                begin
                    mode_next    = mode;
                    rule_next    = fit_rule;
                    own_next     = owner_id;
                    size_next    = ADDR_BITS'(request_size);
                    rel_next     = ADDR_BITS'(release_start);
                    st_next      = ST_OK;
                    gs_next      = '0;
                    gz_next      = '0;
                    idx_next     = '0;
                    wp_next      = '0;
                    pick_ok_next = 1'b0;
                    have_next    = 1'b0;
                    acc_next     = '0;
                    fsum_next    = '0;
                    state_next   = S_STATS;
                    case (mode)
                        MODE_INIT:
                        begin
                            state_next = S_INIT;
                        end
                        MODE_ALLOC:
                        begin
                            if (request_size == '0)
                            begin
                                st_next = ST_ZERO;
                            end
                            else if (fit_rule > FIT_WORST)
                            begin
                                st_next = ST_NO_FIT;
                            end
                            else
                            begin
                                state_next = S_SEARCH;
                            end
                        end
                        MODE_RELEASE:
                        begin
                            st_next    = ST_NO_SEG;
                            state_next = S_SEARCH;
                        end
                        MODE_MERGE:
                        begin
                            state_next = S_MERGE;
                        end
                        MODE_COMPACT:
                        begin
                            state_next = S_COMPACT;
                        end
                        default:
                        begin
                            state_next = S_STATS;
                        end
                    endcase
                end
            end

            S_INIT:
            begin
                wr_en     = 1'b1;
                wr_idx    = '0;
                wr_length = tot_reg;
                wr_free   = 1'b1;
                cnt_next  = CNT_BITS'(1);
                idx_next  = '0;
                boot_next = 1'b0;
                state_next = boot_reg ? S_IDLE : S_STATS;
            end

            // Linear scan: fit search on allocate, address match on release
            S_SEARCH:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        if (!pick_ok_reg)
                        begin
                            st_next    = ST_NO_FIT;
                            idx_next   = '0;
                            state_next = S_STATS;
                        end
                        else
                        begin
                            idx_next   = pick_reg;
                            state_next = S_SPLIT;
                        end
                    end
                    else
                    begin
                        idx_next   = '0;
                        state_next = S_STATS;
                    end
                end
                else if (mode_reg == MODE_RELEASE)
                begin
                    if (!rd_free && rd_start == rel_reg)
                    begin
                        wr_en      = 1'b1;
                        wr_idx     = rd_idx;
                        wr_start   = rd_start;
                        wr_length  = rd_length;
                        wr_free    = 1'b1;
                        st_next    = ST_OK;
                        idx_next   = '0;
                        state_next = S_STATS;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (rd_free && rd_length >= size_reg)
                    begin
                        if (rule_reg == FIT_FIRST)
                        begin
                            pick_ok_next  = 1'b1;
                            pick_next     = idx_reg;
                            pick_len_next = rd_length;
                            idx_next      = idx_reg;
                            state_next    = S_SPLIT;
                        end
                        else if (!pick_ok_reg
                                 || (rule_reg == FIT_BEST && rd_length < pick_len_reg)
                                 || (rule_reg == FIT_WORST && rd_length > pick_len_reg))
                        begin
                            pick_ok_next  = 1'b1;
                            pick_next     = idx_reg;
                            pick_len_next = rd_length;
                        end
                    end
                end
            end

            // Shift entries above the pick up by one from the top, write the pair; else own the hole
            S_SPLIT:
            begin
                if (pick_len_reg > size_reg && cnt_reg < MAXC)
                begin
                    if (idx_reg == pick_reg)
                    begin
                        // idx at pick: shift pointer starts at top
                        if (!have_reg)
                        begin
                            have_next      = 1'b1;
                            acc_start_next = rd_start;
                            idx_next       = cnt_reg - 1'b1;
                            wp_next        = cnt_reg;
                            if (cnt_reg - 1'b1 == pick_reg)
                            begin
                                idx_next = pick_reg;
                                wp_next  = pick_reg + 1'b1;
                            end
                        end
                        if (have_reg || cnt_reg - 1'b1 == pick_reg)
                        begin
                            wr_en     = 1'b1;
                            wr_idx    = IDX_BITS'(pick_reg + 1'b1);
                            wr_start  = (have_reg ? acc_start_reg : rd_start) + size_reg;
                            wr_length = pick_len_reg - size_reg;
                            wr_free   = 1'b1;
                            cnt_next  = cnt_reg + 1'b1;
                            gs_next   = have_reg ? acc_start_reg : rd_start;
                            gz_next   = size_reg;
                            state_next = S_CPT_TAIL;
                        end
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = wp_reg[IDX_BITS-1:0];
                        wr_start  = rd_start;
                        wr_length = rd_length;
                        wr_free   = rd_free;
                        wr_owner  = rd_owner;
                        wp_next   = wp_reg - 1'b1;
                        idx_next  = idx_reg - 1'b1;
                    end
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_idx     = rd_idx;
                    wr_start   = rd_start;
                    wr_length  = rd_length;
                    wr_free    = 1'b0;
                    wr_owner   = own_reg;
                    gs_next    = rd_start;
                    gz_next    = rd_length;
                    idx_next   = '0;
                    state_next = S_STATS;
                end
            end

            // Finish allocate: owned piece at the pick; finish compact: combined free segment at the end
            S_CPT_TAIL:
            begin
                if (mode_reg == MODE_ALLOC)
                begin
                    wr_en      = 1'b1;
                    wr_idx     = pick_reg[IDX_BITS-1:0];
                    wr_start   = gs_reg;
                    wr_length  = size_reg;
                    wr_free    = 1'b0;
                    wr_owner   = own_reg;
                    idx_next   = '0;
                    state_next = S_STATS;
                end
                else
                begin
                    // compact: append combined free segment
                    if (fsum_reg != '0 && wp_reg < MAXC)
                    begin
                        wr_en     = 1'b1;
                        wr_idx    = wp_reg[IDX_BITS-1:0];
                        wr_start  = acc_reg;
                        wr_length = fsum_reg;
                        wr_free   = 1'b1;
                        wp_next   = wp_reg + 1'b1;
                    end
                    cnt_next   = (fsum_reg != '0 && wp_reg < MAXC) ? wp_reg + 1'b1 : wp_reg;
                    idx_next   = '0;
                    state_next = S_STATS;
                end
            end

            // Coalesce: read one entry per cycle, keep a pending run
            S_MERGE:
            begin
                if (idx_reg == cnt_reg)
                begin
                    if (have_reg)
                    begin
                        wr_en     = 1'b1;
                        wr_start  = acc_start_reg;
                        wr_length = acc_reg;
                        wr_free   = acc_free_reg;
                        wr_owner  = acc_own_reg;
                        cnt_next  = wp_reg + 1'b1;
                    end
                    idx_next   = '0;
                    state_next = S_STATS;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (have_reg && acc_free_reg && rd_free)
                    begin
                        acc_next = sum_w[ADDR_BITS-1:0];
                    end
                    else
                    begin
                        if (have_reg)
                        begin
                            wr_en     = 1'b1;
                            wr_start  = acc_start_reg;
                            wr_length = acc_reg;
                            wr_free   = acc_free_reg;
                            wr_owner  = acc_own_reg;
                            wp_next   = wp_reg + 1'b1;
                        end
                        have_next      = 1'b1;
                        acc_next       = rd_length;
                        acc_free_next  = rd_free;
                        acc_start_next = rd_start;
                        acc_own_next   = rd_owner;
                    end
                end
            end

            // Compact: owned entries forward, addresses in acc
            S_COMPACT:
            begin
                if (idx_reg == cnt_reg)
                begin
                    state_next = S_CPT_TAIL;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (rd_free)
                    begin
                        fsum_next = fsum_reg + rd_length;
                    end
                    else
                    begin
                        wr_en     = 1'b1;
                        wr_start  = acc_reg;
                        wr_length = rd_length;
                        wr_free   = 1'b0;
                        wr_owner  = rd_owner;
                        acc_next  = acc_reg + rd_length;
                        wp_next   = wp_reg + 1'b1;
                    end
                end
            end

            // Statistics pass
            S_STATS:
            begin
                if (idx_reg == '0)
                begin
                    fsum_next  = '0;
                    holes_next = '0;
                    big_next   = '0;
                end
                if (idx_reg == cnt_reg)
                begin
                    done_next  = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    if (rd_free)
                    begin
                        fsum_next  = (idx_reg == '0 ? '0 : fsum_reg) + rd_length;
                        holes_next = (idx_reg == '0 ? 6'd0 : holes_reg) + 6'd1;
                        if (idx_reg == '0 || rd_length > big_reg)
                        begin
                            big_next = rd_length;
                        end
                    end
                end
            end

            S_DONE:
            begin
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign status        = st_reg;
    assign granted_start = 16'(gs_reg);
    assign granted_size  = 16'(gz_reg);
    assign free_total    = 16'(fsum_reg);
    assign hole_count    = holes_reg;
    assign largest_hole  = 16'(big_reg);

endmodule

// ----- rtl/vpa_checker.sv -----
`include "assert_macros.svh"

module vpa_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input logic [1:0]  status,
    input logic [15:0] granted_size,
    input logic [5:0]  hole_count,
    input logic [15:0] largest_hole,
    input logic [15:0] free_total
);
    import vpa_pkg::*;

    `ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy, busy)
    `ASSERT_IMPLY(a_done_busy, clk, rst_n, done, busy)
    `ASSERT_IMPLY(a_fail_no_grant, clk, rst_n, done && status != ST_OK, granted_size == '0)
    `ASSERT_IMPLY(a_no_hole_empty, clk, rst_n, done && hole_count == '0,
                  largest_hole == '0 && free_total == '0)

endmodule

bind variable_partition_allocator_core vpa_checker u_vpa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .granted_size (granted_size),
    .hole_count   (hole_count),
    .largest_hole (largest_hole),
    .free_total   (free_total)
);

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import vpa_pkg::*;

    localparam int NSEG = 32;
    localparam int DRAIN_CYCLES = 4 * NSEG + 12;
    localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
    localparam logic [2:0] MODE_UNUSED_HI = 3'd7;
    localparam logic [1:0] FIT_UNKNOWN = 2'd3;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] gstart;
        logic [15:0] gsize;
        logic [15:0] ftotal;
        logic [5:0]  holes;
        logic [15:0] largest;
    } alloc_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [0:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic [2:0]  mode;
    logic [1:0]  fit_rule;
    logic [7:0]  owner_id;
    logic [15:0] request_size;
    logic [15:0] release_start;
    logic        done;
    logic [1:0]  status;
    logic [15:0] granted_start;
    logic [15:0] granted_size;
    logic [15:0] free_total;
    logic [5:0]  hole_count;
    logic [15:0] largest_hole;

    // shadow of the segment table
    logic [15:0] seg_start[NSEG];
    logic [15:0] seg_len[NSEG];
    bit          seg_free[NSEG];
    logic [7:0]  seg_owner[NSEG];
    int          seg_n;
    logic [15:0] cfg_total;

    alloc_result_t pending_results[$];
    int            errors;

    variable_partition_allocator_core DUT (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .mode(mode), .fit_rule(fit_rule), .owner_id(owner_id),
        .request_size(request_size), .release_start(release_start),
        .done(done), .status(status), .granted_start(granted_start),
        .granted_size(granted_size), .free_total(free_total),
        .hole_count(hole_count), .largest_hole(largest_hole)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic void table_clear();
        for (int i = 0; i < NSEG; i++)
        begin
            seg_start[i] = '0;
            seg_len[i] = '0;
            seg_free[i] = 0;
            seg_owner[i] = '0;
        end
    endfunction

    function automatic void table_init();
        table_clear();
        seg_len[0] = cfg_total;
        seg_free[0] = 1;
        seg_n = 1;
    endfunction

    function automatic void copy_entry(int dst, int src);
        seg_start[dst] = seg_start[src];
        seg_len[dst] = seg_len[src];
        seg_free[dst] = seg_free[src];
        seg_owner[dst] = seg_owner[src];
    endfunction

    function automatic void open_after(int pos);
        for (int i = seg_n; i > pos + 1; i--)
            copy_entry(i, i - 1);
        seg_n++;
    endfunction

    function automatic void remove_at(int pos);
        for (int i = pos; i + 1 < seg_n; i++)
            copy_entry(i, i + 1);
        seg_n--;
        seg_start[seg_n] = '0;
        seg_len[seg_n] = '0;
        seg_free[seg_n] = 0;
        seg_owner[seg_n] = '0;
    endfunction

    function automatic int pick_hole(logic [1:0] rule, logic [15:0] size);
        int pick;
        pick = -1;
        if (rule == FIT_UNKNOWN)
            return -1;
        for (int i = 0; i < seg_n; i++)
        begin
            if (!seg_free[i] || seg_len[i] < size)
                continue;
            if (rule == FIT_FIRST)
                return i;
            if (pick < 0 || (rule == FIT_BEST && seg_len[i] < seg_len[pick]) ||
                (rule == FIT_WORST && seg_len[i] > seg_len[pick]))
                pick = i;
        end
        return pick;
    endfunction

    function automatic void merge_holes();
        int i;
        i = 0;
        while (i + 1 < seg_n)
        begin
            if (seg_free[i] && seg_free[i + 1])
            begin
                seg_len[i] = seg_len[i] + seg_len[i + 1];
                remove_at(i + 1);
            end
            else
                i++;
        end
    endfunction

    function automatic void compact_table();
        int n;
        int unsigned fsum;
        logic [15:0] addr;
        n = 0;
        fsum = 0;
        addr = '0;
        for (int i = 0; i < seg_n; i++)
        begin
            if (seg_free[i])
                fsum += seg_len[i];
            else
            begin
                seg_len[n] = seg_len[i];
                seg_owner[n] = seg_owner[i];
                seg_free[n] = 0;
                n++;
            end
        end
        if (fsum > 0 && n < NSEG)
        begin
            seg_len[n] = fsum[15:0];
            seg_owner[n] = '0;
            seg_free[n] = 1;
            n++;
        end
        for (int i = n; i < NSEG; i++)
        begin
            seg_start[i] = '0;
            seg_len[i] = '0;
            seg_free[i] = 0;
            seg_owner[i] = '0;
        end
        seg_n = n;
        for (int i = 0; i < n; i++)
        begin
            seg_start[i] = addr;
            addr = addr + seg_len[i];
        end
    endfunction

    function automatic alloc_result_t predict_command(logic [2:0] md, logic [1:0] rule,
        logic [7:0] own, logic [15:0] size, logic [15:0] rel);
        alloc_result_t r;
        int k;
        int unsigned fsum;
        r = '{default: '0};
        r.status = ST_OK;
        fsum = 0;
        case (md)
            MODE_INIT: table_init();
            MODE_ALLOC:
            begin
                if (size == 0)
                    r.status = ST_ZERO;
                else
                begin
                    k = pick_hole(rule, size);
                    if (k < 0)
                        r.status = ST_NO_FIT;
                    else
                    begin
                        if (seg_len[k] > size && seg_n < NSEG)
                        begin
                            open_after(k);
                            seg_start[k + 1] = seg_start[k] + size;
                            seg_len[k + 1] = seg_len[k] - size;
                            seg_free[k + 1] = 1;
                            seg_owner[k + 1] = '0;
                            seg_len[k] = size;
                        end
                        seg_free[k] = 0;
                        seg_owner[k] = own;
                        r.gstart = seg_start[k];
                        r.gsize = seg_len[k];
                    end
                end
            end
            MODE_RELEASE:
            begin
                r.status = ST_NO_SEG;
                for (int i = 0; i < seg_n; i++)
                begin
                    if (!seg_free[i] && seg_start[i] == rel)
                    begin
                        seg_free[i] = 1;
                        seg_owner[i] = '0;
                        r.status = ST_OK;
                        break;
                    end
                end
            end
            MODE_MERGE: merge_holes();
            MODE_COMPACT: compact_table();
            default: ;
        endcase
        for (int i = 0; i < seg_n; i++)
        begin
            if (seg_free[i])
            begin
                fsum += seg_len[i];
                r.holes++;
                if (seg_len[i] > r.largest)
                    r.largest = seg_len[i];
            end
        end
        r.ftotal = fsum[15:0];
        return r;
    endfunction

    always @(posedge clk)
    begin
        alloc_result_t e;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                errors++;
            end
            else
            begin
                e = pending_results.pop_front();
                if (status !== e.status)
                begin
                    $error("status: expected %0d, got %0d", e.status, status);
                    errors++;
                end
                if (granted_start !== e.gstart)
                begin
                    $error("granted_start: expected %0d, got %0d", e.gstart, granted_start);
                    errors++;
                end
                if (granted_size !== e.gsize)
                begin
                    $error("granted_size: expected %0d, got %0d", e.gsize, granted_size);
                    errors++;
                end
                if (free_total !== e.ftotal)
                begin
                    $error("free_total: expected %0d, got %0d", e.ftotal, free_total);
                    errors++;
                end
                if (hole_count !== e.holes)
                begin
                    $error("hole_count: expected %0d, got %0d", e.holes, hole_count);
                    errors++;
                end
                if (largest_hole !== e.largest)
                begin
                    $error("largest_hole: expected %0d, got %0d", e.largest, largest_hole);
                    errors++;
                end
            end
        end
    end

    task automatic send_command(logic [2:0] md, logic [1:0] rule, logic [7:0] own,
        logic [15:0] size, logic [15:0] rel);
        @(negedge clk);
        mode = md;
        fit_rule = rule;
        owner_id = own;
        request_size = size;
        release_start = rel;
        start = 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_command(md, rule, own, size, rel));
        @(negedge clk);
        start = 1'b0;
    endtask

    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 3);
        if ($urandom_range(0, 3) == 0)
            n = 0;
        repeat (n) @(negedge clk);
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_total(logic [15:0] value);
        wait_drained();
        @(negedge clk);
        psel = 1'b1;
        pwrite = 1'b1;
        paddr = REG_TOTAL_SIZE[0:0];
        pwdata = {16'($urandom_range(0, 65535)), value};
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        cfg_total = value;
    endtask

    function automatic logic [15:0] owned_start();
        int idx[$];
        for (int i = 0; i < seg_n; i++)
            if (!seg_free[i])
                idx.push_back(i);
        if (idx.size() == 0)
            return 16'($urandom);
        return seg_start[idx[$urandom_range(0, idx.size() - 1)]];
    endfunction

    task automatic test_after_reset();
        send_command(MODE_MERGE, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_ALLOC, FIT_FIRST, 8'hff, 16'hffff, 16'hffff);
        send_command(MODE_RELEASE, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_INIT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
    endtask

    task automatic test_special_cases();
        send_command(MODE_ALLOC, FIT_FIRST, 8'd7, 16'd0, 16'd0);
        send_command(MODE_ALLOC, FIT_UNKNOWN, 8'd7, 16'd10, 16'd0);
        send_command(MODE_ALLOC, FIT_FIRST, 8'd1, 16'd100, 16'd0);
        send_command(MODE_ALLOC, FIT_FIRST, 8'd2, 16'd50, 16'd0);
        send_command(MODE_ALLOC, FIT_FIRST, 8'd3, 16'd100, 16'd0);
        send_command(MODE_ALLOC, FIT_FIRST, 8'd4, 16'd10, 16'd0);
        send_command(MODE_RELEASE, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_RELEASE, FIT_FIRST, 8'd0, 16'd150, 16'd150);
        send_command(MODE_RELEASE, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_RELEASE, FIT_FIRST, 8'd0, 16'd0, 16'd7);
        send_command(MODE_ALLOC, FIT_BEST, 8'd5, 16'd40, 16'd0);
        send_command(MODE_ALLOC, FIT_WORST, 8'd6, 16'd40, 16'd0);
        for (logic [3:0] m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
            send_command(m[2:0], FIT_FIRST, 8'd0, 16'd1, 16'd1);
        send_command(MODE_MERGE, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_COMPACT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
    endtask

    task automatic test_full_table();
        write_total(16'd40);
        send_command(MODE_INIT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        for (int i = 0; i < NSEG; i++)
            send_command(MODE_ALLOC, FIT_FIRST, 8'(i + 1), 16'd1, 16'd0);
        send_command(MODE_ALLOC, FIT_FIRST, 8'd99, 16'd1, 16'd0);
        send_command(MODE_COMPACT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_RELEASE, FIT_FIRST, 8'd0, 16'd0, 16'd3);
        send_command(MODE_COMPACT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
    endtask

    task automatic test_register_extremes();
        write_total(16'd0);
        send_command(MODE_INIT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_ALLOC, FIT_WORST, 8'd1, 16'd1, 16'd0);
        write_total(16'd1);
        send_command(MODE_ALLOC, FIT_FIRST, 8'd1, 16'd1, 16'd0);
        send_command(MODE_INIT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_ALLOC, FIT_BEST, 8'd1, 16'd1, 16'd0);
        write_total(16'hffff);
        send_command(MODE_INIT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
        send_command(MODE_ALLOC, FIT_BEST, 8'd1, 16'hffff, 16'd0);
    endtask

    task automatic test_random_traffic(int count);
        int sel;
        logic [2:0]  md;
        logic [1:0]  rule;
        logic [15:0] size;
        logic [15:0] rel;
        logic [15:0] cap;
        for (int n = 0; n < count; n++)
        begin
            sel = $urandom_range(0, 99);
            rule = ($urandom_range(0, 19) == 0) ? FIT_UNKNOWN : 2'($urandom_range(0, 2));
            cap = (cfg_total > 16'd8) ? cfg_total / 8 : 16'd2;
            size = 16'($urandom_range(1, cap));
            if ($urandom_range(0, 19) == 0)
                size = 16'($urandom);
            else if ($urandom_range(0, 29) == 0)
                size = '0;
            rel = 16'($urandom);
            if (sel < 48)
                md = MODE_ALLOC;
            else if (sel < 84)
            begin
                md = MODE_RELEASE;
                if ($urandom_range(0, 9) != 0)
                    rel = owned_start();
            end
            else if (sel < 92)
                md = MODE_MERGE;
            else if (sel < 96)
                md = MODE_COMPACT;
            else if (sel < 98)
                md = MODE_INIT;
            else
                md = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
            send_command(md, rule, 8'($urandom), size, rel);
            idle_gap();
        end
    endtask

    task automatic test_random_phases();
        logic [15:0] sizes[4];
        sizes = '{16'hffff, 16'd64, 16'($urandom_range(1, 65535)), 16'd1000};
        foreach (sizes[p])
        begin
            write_total(sizes[p]);
            send_command(MODE_INIT, FIT_FIRST, 8'd0, 16'd0, 16'd0);
            test_random_traffic(310);
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        mode = MODE_INIT;
        fit_rule = FIT_FIRST;
        owner_id = '0;
        request_size = '0;
        release_start = '0;
        errors = 0;
        cfg_total = 16'hffff;
        table_init();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_after_reset();
        test_special_cases();
        test_full_table();
        test_register_extremes();
        test_random_phases();

        wait_drained();
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// ----- files.f -----
+incdir+rtl
rtl/vpa_pkg.sv
rtl/vpa_table.sv
rtl/vpa_ctrl.sv
rtl/variable_partition_allocator_core.sv
rtl/vpa_checker.sv
tb/testbench.sv
